// File: design/sfs_pkg.sv
// Shared types, codes and helpers of the string field splitter.
package sfs_pkg;

	// Result codes carried on the kind field.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Configuration register indexes.
	localparam int         CFG_IDX_W       = 2;
	localparam logic [1:0] CFG_WS_MODE     = 2'd0;
	localparam logic [1:0] CFG_DELIM_LEN   = 2'd1;
	localparam logic [1:0] CFG_DELIM_BYTES = 2'd2;

	// One result word as it moves between the staging and output registers.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_char;
		logic [15:0] field_count;
	} res_t;

	// True for space, tab, newline, carriage return, form feed and vertical tab.
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
			(c == 8'h0C) || (c == 8'h0B);
	endfunction

endpackage

// File: design/sfs_ifs.sv
// Handshake interfaces for the input, output and configuration channels.
interface sfs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       has_char;
	logic       end_of_string;

	modport source (output valid, output ch, output has_char, output end_of_string,
		input ready);
	modport sink (input valid, input ch, input has_char, input end_of_string,
		output ready);
endinterface

interface sfs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_char;
	logic [15:0] field_count;
	logic        last;

	modport source (output valid, output kind, output out_char, output field_count,
		output last, input ready);
	modport sink (input valid, input kind, input out_char, input field_count,
		input last, output ready);
endinterface

interface sfs_cfg_if;
	import sfs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [63:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/string_field_splitter_unit.sv
// String field splitter: streams field bytes and field-end marks from a byte stream.
// A word is accepted in the idle state; each result is produced one per cycle by the
// scan sequencer while the staging register can take it, and reaches the output register
// when the next result is produced, the last one in the closing step. A failed partial
// match releases its held bytes one at a time. The next word is taken only when the
// sequencer is idle. Async active-low reset loads defaults, except into payload registers.
module string_field_splitter_unit #(
	parameter int MAX_DELIM = 8
) (
	input logic        clk,
	input logic        arst_n,
	sfs_in_if.sink     din,
	sfs_out_if.source  dout,
	sfs_cfg_if.sink    cfg
);
	import sfs_pkg::*;

	localparam int CAP   = (MAX_DELIM < 8) ? MAX_DELIM : 8;
	localparam int BUF_D = MAX_DELIM + 1;
	localparam int NW    = $clog2(BUF_D + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WS    = 6'b000010,
		S_ERR   = 6'b000100,
		S_SCAN  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	// Configuration registers.
	logic        ws_mode_q;
	logic [3:0]  delim_len_q;
	logic [63:0] delim_q;

	// Sequencer state.
	state_t         state_q, state_d;
	logic [7:0]     buf_q [BUF_D];
	logic [7:0]     buf_d [BUF_D];
	logic [7:0]     buf_sh [BUF_D];
	logic [NW-1:0]  n_q, n_d;
	logic [7:0]     ch_q, ch_d;
	logic           ch_pend_q, ch_pend_d;
	logic           eos_q, eos_d;
	logic           in_word_q, in_word_d;
	logic           at_start_q, at_start_d;
	logic [15:0]    fields_q, fields_d;

	// Staging and output registers.
	logic held_v_q;
	res_t held_q;
	logic out_v_q;
	res_t out_q;
	logic out_last_q;

	logic        out_free, can_prod, prod, fin_push, push_out;
	res_t        prod_res;
	logic [15:0] fields_inc;
	logic [3:0]  eff, sh;
	logic        match_ok, full, partial;

	assign cfg.ready = 1'b1;
	assign din.ready = (state_q == S_IDLE);

	assign dout.valid       = out_v_q;
	assign dout.kind        = out_q.kind;
	assign dout.out_char    = out_q.out_char;
	assign dout.field_count = out_q.field_count;
	assign dout.last        = out_last_q;

	// Effective delimiter length, clipped to the comparator capacity (MAX_DELIM, at most 8).
	assign eff = (delim_len_q > 4'(CAP)) ? 4'(CAP) : delim_len_q;

	assign fields_inc = (fields_q == 16'hFFFF) ? fields_q : fields_q + 16'd1;
	assign out_free   = !out_v_q || dout.ready;
	assign can_prod   = !held_v_q || out_free;

	// Byte comparator: held bytes against the delimiter prefix.
	always_comb begin
		match_ok = 1'b1;
		for (int k = 0; k < CAP; k++) begin
			if (k < int'(n_q) && k < int'(eff) && buf_q[k] != delim_q[8*k +: 8]) begin
				match_ok = 1'b0;
			end
		end
	end

	assign full    = match_ok && (int'(n_q) >= int'(eff));
	assign partial = match_ok && !full;

	// Consume one byte, or a whole delimiter on a full match.
	assign sh = (state_q == S_SCAN && full) ? eff : 4'd1;

	always_comb begin
		for (int i = 0; i < BUF_D; i++) begin
			buf_sh[i] = buf_q[i];
			for (int s = 1; s <= CAP; s++) begin
				if (sh == 4'(s) && i + s < BUF_D) begin
					buf_sh[i] = buf_q[i + s];
				end
			end
		end
	end

	// Sequencer: one result step per cycle while the staging register can take a result.
	always_comb begin
		logic done;
		done       = 1'b0;
		state_d    = state_q;
		buf_d      = buf_q;
		n_d        = n_q;
		ch_d       = ch_q;
		ch_pend_d  = ch_pend_q;
		eos_d      = eos_q;
		in_word_d  = in_word_q;
		at_start_d = at_start_q;
		fields_d   = fields_q;
		prod       = 1'b0;
		prod_res   = '0;
		fin_push   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (din.valid && (din.has_char || din.end_of_string)) begin
					ch_d      = din.ch;
					ch_pend_d = din.has_char;
					eos_d     = din.end_of_string;
					if (ws_mode_q) begin
						state_d = S_WS;
					end else if (eff == 4'd0) begin
						state_d = S_ERR;
					end else begin
						state_d = S_SCAN;
						if (din.has_char) begin
							for (int i = 0; i < BUF_D; i++) begin
								if (i == int'(n_q)) begin
									buf_d[i] = din.ch;
								end
							end
							n_d = n_q + NW'(1);
						end
					end
				end
			end
			S_WS: begin
				if (ch_pend_q) begin
					if (is_space(ch_q)) begin
						if (!in_word_q) begin
							ch_pend_d = 1'b0;
						end else if (can_prod) begin
							prod      = 1'b1;
							prod_res  = '{kind: KIND_END, out_char: 8'd0, field_count: fields_inc};
							fields_d  = fields_inc;
							in_word_d = 1'b0;
							ch_pend_d = 1'b0;
						end
					end else if (can_prod) begin
						prod       = 1'b1;
						prod_res   = '{kind: KIND_BYTE, out_char: ch_q, field_count: fields_q};
						in_word_d  = 1'b1;
						at_start_d = 1'b0;
						ch_pend_d  = 1'b0;
					end
				end else if (eos_q && (in_word_q || at_start_q)) begin
					if (can_prod) begin
						prod     = 1'b1;
						prod_res = '{kind: KIND_END, out_char: 8'd0, field_count: fields_inc};
						fields_d = fields_inc;
						state_d  = S_FIN;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_ERR: begin
				if (can_prod) begin
					prod     = 1'b1;
					prod_res = '{kind: KIND_ERR, out_char: 8'd0, field_count: fields_q};
					state_d  = S_FIN;
				end
			end
			S_SCAN: begin
				if (n_q == '0 || partial) begin
					state_d = eos_q ? S_DRAIN : S_FIN;
				end else if (can_prod) begin
					prod  = 1'b1;
					buf_d = buf_sh;
					if (full) begin
						prod_res = '{kind: KIND_END, out_char: 8'd0, field_count: fields_inc};
						fields_d = fields_inc;
						n_d      = n_q - NW'(eff);
					end else begin
						prod_res = '{kind: KIND_BYTE, out_char: buf_q[0], field_count: fields_q};
						n_d      = n_q - NW'(1);
					end
				end
			end
			S_DRAIN: begin
				if (can_prod) begin
					prod = 1'b1;
					if (n_q != '0) begin
						prod_res = '{kind: KIND_BYTE, out_char: buf_q[0], field_count: fields_q};
						buf_d    = buf_sh;
						n_d      = n_q - NW'(1);
					end else begin
						prod_res = '{kind: KIND_END, out_char: 8'd0, field_count: fields_inc};
						fields_d = fields_inc;
						state_d  = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (held_v_q) begin
					if (out_free) begin
						fin_push = 1'b1;
						done     = 1'b1;
					end
				end else begin
					done = 1'b1;
				end
				if (done) begin
					state_d = S_IDLE;
					if (eos_q) begin
						in_word_d  = 1'b0;
						at_start_d = 1'b1;
						n_d        = '0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A new result pushes the staged one out; the closing step pushes it as the last.
	assign push_out = (prod && held_v_q) || fin_push;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_mode_q   <= 1'b1;
			delim_len_q <= 4'd1;
			delim_q     <= 64'd44;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_WS_MODE:     ws_mode_q   <= cfg.data[0];
				CFG_DELIM_LEN:   delim_len_q <= cfg.data[3:0];
				CFG_DELIM_BYTES: delim_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and string state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			ch_pend_q  <= 1'b0;
			eos_q      <= 1'b0;
			in_word_q  <= 1'b0;
			at_start_q <= 1'b1;
			fields_q   <= 16'd0;
			held_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			n_q        <= n_d;
			ch_pend_q  <= ch_pend_d;
			eos_q      <= eos_d;
			in_word_q  <= in_word_d;
			at_start_q <= at_start_d;
			fields_q   <= fields_d;
			if (prod) begin
				held_v_q <= 1'b1;
			end else if (fin_push) begin
				held_v_q <= 1'b0;
			end
			if (push_out) begin
				out_v_q    <= 1'b1;
				out_last_q <= fin_push;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		ch_q  <= ch_d;
		if (prod) begin
			held_q <= prod_res;
		end
		if (push_out) begin
			out_q <= held_q;
		end
	end

endmodule

// File: design/sfs_checker.sv
// Port-level checker for the string field splitter, bound to the splitter unit.
module sfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        din_valid,
	input logic        din_ready,
	input logic        din_has_char,
	input logic        din_eos,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [7:0]  out_char,
	input logic [15:0] out_count,
	input logic        out_last
);
	import sfs_pkg::*;

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_kind, out_char, out_count, out_last}))
		else $error("output word changed while stalled");

	// An empty-delimiter error is the only result of its word.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_ERR |-> out_last)
		else $error("error result not marked last");

	// Only field bytes carry a byte value.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_BYTE |-> out_char == 8'd0)
		else $error("non-byte result carries a byte");

	// A word that carries a byte or an end keeps the input closed the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		din_valid && din_ready && (din_has_char || din_eos) |=> !din_ready)
		else $error("input taken again right after a working word");

endmodule

bind string_field_splitter_unit sfs_checker u_sfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.din_valid    (din.valid),
	.din_ready    (din.ready),
	.din_has_char (din.has_char),
	.din_eos      (din.end_of_string),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.out_kind     (dout.kind),
	.out_char     (dout.out_char),
	.out_count    (dout.field_count),
	.out_last     (dout.last)
);

// File: dv/tb_top.sv
// Self-checking testbench for the string field splitter: directed table, then random strings.
module tb_top;
	import sfs_pkg::*;

	localparam int MAX_PIECES = 10;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS [PHASES] = '{45, 45, 45, 15, 50, 45, 45, 45};

	// One result word: kind, byte, running field count and last flag.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  chr;
		logic [15:0] count;
		logic        lst;
	} frag_t;

	// One row of the directed table: either a register write or an input word.
	typedef struct {
		bit        is_reg;
		bit [1:0]  idx;
		bit [63:0] data;
		bit [7:0]  ch;
		bit        has;
		bit        eos;
		bit        pinned;
		frag_t     want;
	} row_t;

	logic clk;
	logic arst_n;

	sfs_in_if  in_ch ();
	sfs_out_if out_ch ();
	sfs_cfg_if cfg_ch ();

	string_field_splitter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the configuration registers.
	bit        ws_mode  = 1'b1;
	bit [3:0]  dlen     = 4'd1;
	bit [63:0] dbytes   = 64'd44;

	// Mirror of the splitter state.
	bit [7:0]  held [8];
	int        held_n      = 0;
	bit [15:0] fields_done = '0;
	bit        in_word     = 1'b0;
	bit        at_start    = 1'b1;

	// Results of the word being predicted, and the stream still owed by the block.
	frag_t     step_res [MAX_PIECES];
	int        step_n;
	bit [7:0]  scan_buf [9];
	frag_t     field_stream_q [$];

	int        items_sent = 0;
	int        errors     = 0;
	int        cycles     = 0;
	bit        quiet      = 1'b0;
	int        stall_left = 0;
	row_t      script [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle budget for the whole run.
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic bit roll_idle();
		return !quiet && ($urandom_range(0, 99) < 7);
	endfunction

	function automatic bit is_blank(input bit [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};
	endfunction

	function automatic int delim_eff();
		return (dlen > 4'd8) ? 8 : int'(dlen);
	endfunction

	function automatic void emit(input bit [1:0] k, input bit [7:0] c);
		if (step_n < MAX_PIECES) begin
			step_res[step_n] = '{k, (k == KIND_BYTE) ? c : 8'd0, fields_done, 1'b0};
			step_n++;
		end
	endfunction

	function automatic void close_field();
		if (fields_done != 16'hFFFF)
			fields_done++;
		emit(KIND_END, 8'd0);
	endfunction

	// True when the scan buffer from position 'from' matches the first 'len' delimiter bytes.
	function automatic bit delim_at(input int from, input int len);
		for (int i = 0; i < len; i++)
			if (scan_buf[from + i] != dbytes[8 * i +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	// Works out the results of one input word and advances the mirrored state.
	function automatic void split_byte(input bit [7:0] ch, input bit has, input bit eos);
		int eff;
		int n;
		int pos;
		step_n = 0;
		if (!has && !eos)
			return;
		if (ws_mode) begin
			if (has) begin
				if (is_blank(ch)) begin
					if (in_word) begin
						close_field();
						in_word = 1'b0;
					end
				end else begin
					emit(KIND_BYTE, ch);
					in_word = 1'b1;
					at_start = 1'b0;
				end
			end
			if (eos && (in_word || at_start))
				close_field();
		end else begin
			eff = delim_eff();
			if (eff == 0) begin
				emit(KIND_ERR, 8'd0);
			end else begin
				n = held_n;
				for (int i = 0; i < n; i++)
					scan_buf[i] = held[i];
				if (has) begin
					scan_buf[n] = ch;
					n++;
				end
				pos = 0;
				// Leftmost, non-overlapping match; a partial match at the tail stays held.
				while (pos < n) begin
					if (n - pos >= eff && delim_at(pos, eff)) begin
						close_field();
						pos += eff;
					end else if (n - pos < eff && delim_at(pos, n - pos)) begin
						break;
					end else begin
						emit(KIND_BYTE, scan_buf[pos]);
						pos++;
					end
				end
				if (eos) begin
					for (int i = pos; i < n; i++)
						emit(KIND_BYTE, scan_buf[i]);
					close_field();
				end else begin
					held_n = n - pos;
					for (int i = 0; i < held_n; i++)
						held[i] = scan_buf[pos + i];
				end
			end
		end
		if (eos) begin
			in_word = 1'b0;
			at_start = 1'b1;
			held_n = 0;
		end
		if (step_n > 0)
			step_res[step_n - 1].lst = 1'b1;
	endfunction

	// Offers one input word, with random gaps, and records what it must produce.
	task automatic send_word(input bit [7:0] ch, input bit has, input bit eos,
		input bit pinned = 1'b0, input frag_t pinned_res = '0);
		@(negedge clk);
		while (roll_idle()) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.ch <= ch;
		in_ch.has_char <= has;
		in_ch.end_of_string <= eos;
		do @(posedge clk); while (!in_ch.ready);
		split_byte(ch, has, eos);
		if (pinned)
			field_stream_q.push_back(pinned_res);
		else
			for (int i = 0; i < step_n; i++)
				field_stream_q.push_back(step_res[i]);
		if (has || eos)
			items_sent++;
	endtask

	// Drops valid and waits until the block has delivered everything and gone quiet.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (field_stream_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_WS_MODE:     ws_mode = val[0];
			CFG_DELIM_LEN:   dlen = val[3:0];
			CFG_DELIM_BYTES: dbytes = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic row_t r_byte(input bit [7:0] c, input bit has, input bit eos);
		row_t r;
		r = '{default: '0};
		r.ch = c;
		r.has = has;
		r.eos = eos;
		return r;
	endfunction

	function automatic row_t r_known(input bit [7:0] c, input bit has, input bit eos,
		input bit [1:0] k, input bit [7:0] oc, input bit [15:0] cnt);
		row_t r;
		r = r_byte(c, has, eos);
		r.pinned = 1'b1;
		r.want = '{k, oc, cnt, 1'b1};
		return r;
	endfunction

	function automatic row_t r_reg(input bit [1:0] idx, input bit [63:0] val);
		row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.idx = idx;
		r.data = val;
		return r;
	endfunction

	// Random data bits above the field that a register actually uses.
	function automatic bit [63:0] with_noise(input bit [63:0] low, input bit [63:0] keep);
		return ({$urandom(), $urandom()} & ~keep) | low;
	endfunction

	function automatic bit [7:0] pick_byte();
		int r;
		int eff;
		r = $urandom_range(0, 99);
		eff = delim_eff();
		if (r < 25) begin
			if (ws_mode)
				case ($urandom_range(0, 5))
					0: return 8'h20;
					1: return 8'h09;
					2: return 8'h0A;
					3: return 8'h0D;
					4: return 8'h0C;
					default: return 8'h0B;
				endcase
			else if (eff > 0)
				return dbytes[8 * $urandom_range(0, eff - 1) +: 8];
		end
		if (r < 85)
			return 8'h61 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bit [63:0] pick_delim();
		bit [63:0] d;
		for (int i = 0; i < 8; i++)
			d[8 * i +: 8] = ($urandom_range(0, 9) < 6) ? 8'h61 + 8'($urandom_range(0, 3))
				: 8'($urandom_range(0, 255));
		return d;
	endfunction

	// One string: mostly ordinary bytes, whole or partial delimiters, stray bare words.
	task automatic send_string();
		int len;
		int r;
		int k;
		int j;
		int eff;
		len = $urandom_range(0, 10);
		eff = delim_eff();
		k = 0;
		while (k < len) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else if (!ws_mode && eff > 0 && r < 25) begin
				j = (r < 17) ? eff : $urandom_range(1, eff);
				for (int i = 0; i < j; i++)
					send_word(dbytes[8 * i +: 8], 1'b1, 1'b0);
				k += j;
			end else begin
				send_word(pick_byte(), 1'b1, 1'b0);
				k++;
			end
		end
		if ($urandom_range(0, 1))
			send_word(pick_byte(), 1'b1, 1'b1);
		else
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Register settings per random phase, extremes among them.
	task automatic setup_phase(input int p);
		bit        ws;
		bit [3:0]  len;
		ws = 1'b0;
		len = 4'($urandom_range(1, 8));
		case (p)
			0: ws = 1'b1;
			1: len = 4'd1;
			2: len = 4'd8;
			3: len = 4'd0;
			4: len = 4'($urandom_range(2, 4));
			5: ws = 1'b1;
			6: len = 4'd15;
			default: len = 4'($urandom_range(0, 15));
		endcase
		write_reg(CFG_DELIM_BYTES, pick_delim());
		write_reg(CFG_DELIM_LEN, with_noise(64'(len), 64'hF));
		write_reg(CFG_WS_MODE, with_noise(64'(ws), 64'h1));
	endtask

	// Receiver: random back-pressure, plus a long hold-off when one is requested.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !roll_idle();
			end
		end
	end

	// Compare every delivered word against the oldest expectation.
	always @(posedge clk) begin
		frag_t got;
		frag_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.kind, out_ch.out_char, out_ch.field_count, out_ch.last};
			if (field_stream_q.size() == 0) begin
				$display("%0t: unexpected word kind %0d char %02h count %0d last %0b",
					$time, got.kind, got.chr, got.count, got.lst);
				errors++;
			end else begin
				want = field_stream_q.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch: expected kind %0d char %02h count %0d last %0b,",
						$time, want.kind, want.chr, want.count, want.lst,
						" got kind %0d char %02h count %0d last %0b",
						got.kind, got.chr, got.count, got.lst);
					errors++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, random phases, then drain and report.
	initial begin
		int  goal;
		bit  paused;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.ch = '0;
		in_ch.has_char = 1'b0;
		in_ch.end_of_string = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Whitespace mode from reset: words, runs, bare words, all-blank strings.
		script.push_back(r_known(8'h61, 1, 0, KIND_BYTE, 8'h61, 16'd0));
		script.push_back(r_known(8'h20, 1, 0, KIND_END, 8'h00, 16'd1));
		script.push_back(r_byte(8'h09, 1, 0));
		script.push_back(r_known(8'hFF, 1, 0, KIND_BYTE, 8'hFF, 16'd1));
		script.push_back(r_byte(8'h55, 0, 0));
		script.push_back(r_known(8'h00, 0, 1, KIND_END, 8'h00, 16'd2));
		script.push_back(r_known(8'h0A, 1, 1, KIND_END, 8'h00, 16'd3));
		script.push_back(r_byte(8'h0D, 1, 0));
		script.push_back(r_byte(8'h0C, 1, 0));
		script.push_back(r_known(8'h0B, 1, 1, KIND_END, 8'h00, 16'd4));
		script.push_back(r_byte(8'h00, 1, 1));
		// Comma delimiter: empty fields and a trailing empty field.
		script.push_back(r_reg(CFG_WS_MODE, 64'd0));
		script.push_back(r_byte(8'h78, 1, 0));
		script.push_back(r_byte(8'h2C, 1, 0));
		script.push_back(r_byte(8'h2C, 1, 1));
		// Empty delimiter reports an error for a byte and for a bare end.
		script.push_back(r_reg(CFG_DELIM_LEN, 64'd0));
		script.push_back(r_known(8'h71, 1, 0, KIND_ERR, 8'h00, 16'd8));
		script.push_back(r_known(8'h00, 0, 1, KIND_ERR, 8'h00, 16'd8));
		// Overlapping delimiter "aa" on "aaa": no extra trailing field.
		script.push_back(r_reg(CFG_DELIM_BYTES, 64'h6161));
		script.push_back(r_reg(CFG_DELIM_LEN, 64'd2));
		script.push_back(r_byte(8'h61, 1, 0));
		script.push_back(r_byte(8'h61, 1, 0));
		script.push_back(r_byte(8'h61, 1, 1));
		// Oversized length caps at eight; a failed partial match releases held bytes.
		script.push_back(r_reg(CFG_DELIM_LEN, 64'd15));
		script.push_back(r_reg(CFG_DELIM_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
		script.push_back(r_byte(8'hFF, 1, 0));
		script.push_back(r_byte(8'hFF, 1, 0));
		script.push_back(r_byte(8'h00, 1, 0));
		// Held bytes rescanned against a shorter delimiter set mid-string.
		script.push_back(r_byte(8'hFF, 1, 0));
		script.push_back(r_byte(8'hFF, 1, 0));
		script.push_back(r_reg(CFG_DELIM_LEN, 64'd1));
		script.push_back(r_byte(8'h62, 1, 1));

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				settle();
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_word(script[i].ch, script[i].has, script[i].eos,
					script[i].pinned, script[i].want);
			end
		end

		// Random phases; registers change only between them.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			setup_phase(p);
			// Long receiver hold-off while words keep coming, so the block backs up.
			if (p == 2)
				stall_left = 300;
			quiet = (p == 4);
			paused = 1'b0;
			goal = items_sent + PHASE_ITEMS[p];
			while (items_sent < goal) begin
				send_string();
				// Sender stops until every outstanding result has come back.
				if (p == 5 && !paused && items_sent >= goal - PHASE_ITEMS[p] / 2) begin
					settle();
					paused = 1'b1;
				end
			end
		end
		quiet = 1'b0;

		settle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
design/sfs_pkg.sv
design/sfs_ifs.sv
design/string_field_splitter_unit.sv
design/sfs_checker.sv
dv/tb_top.sv
